// ----- design/tsha_pkg.sv -----
// Shared constants, types and helpers for the thermistor averager
package tsha_pkg;

    localparam int BatchSamples = 10;
    localparam int AdcFullScale = 1024;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 24;

    localparam logic [CfgIdxW-1:0] CFG_SENSOR_TYPE = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_REFERENCE_OHMS = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_SUPPLY_VOLTS = 2'd2;

    localparam logic [33:0] RES_MAX = 34'h3_FFFF_FFFF;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // Input request payload
    typedef struct packed {
        logic [9:0] adc_sample;
    } in_item_t;

    // Result request payload
    typedef struct packed {
        logic signed [15:0] temperature_q8_8;
        logic [33:0]        mean_resistance_ohms;
        logic               zero_sample_seen;
        logic               result_saturated;
    } out_item_t;

    // Cubic coefficients in Q8.24, index 0 is the constant term
    function automatic logic signed [31:0] coef(input logic set_b, input logic [1:0] idx);
        logic signed [31:0] c;
        begin
            c = '0;
            case ({set_b, idx})
                3'd0: c = -32'sd73090152;
                3'd1: c = 32'sd31740067;
                3'd2: c = -32'sd4612119;
                3'd3: c = 32'sd225240;
                3'd4: c = 32'sd204915072;
                3'd5: c = -32'sd41846897;
                3'd6: c = 32'sd2857366;
                default: c = -32'sd65159;
            endcase
            return c;
        end
    endfunction

endpackage

// ----- design/tsha_stream_if.sv -----
// Valid/ready channel interface carrying one payload type
interface tsha_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/tsha_divider.sv -----
// Shared restoring divider, one quotient bit per cycle
module tsha_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [39:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    logic [63:0] quo_reg;
    logic [40:0] rem_reg;
    logic [39:0] div_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic [40:0] trial;
    logic [40:0] shifted;

    assign shifted = {rem_reg[39:0], quo_reg[63]};
    assign trial = shifted - {1'b0, div_reg};
    assign quotient = quo_reg;
    assign done = busy_reg && (cnt_reg == 7'd0);

    // One subtract and compare per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= 7'd64;
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 7'd0)
                busy_reg <= 1'b0;
            else
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (!trial[40])
                begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= shifted;
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
            end
        end
    end
endmodule

// ----- design/thermistor_steinhart_hart_averager_top.sv -----
// Top level: resistance averaging, logarithm, cubic fit and reciprocal
// A sample that does not end a batch keeps in.ready low through S_RDIV and S_RWAIT (one
// 64-step divide); the next sample is taken once back in S_IDLE with no result waiting.
// The batch-ending sample goes through divide, shift-add mean with up to two fix-up steps,
// 26 squarings, 3 Horner steps and a divide before its result is shown.
// Throughput: one sample at a time; in.ready is low while a sample is worked on or a result waits.
// Reset clears batch state and sets the registers to type 0, 10000 ohms, 5 volts.
module thermistor_steinhart_hart_averager_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [tsha_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [tsha_pkg::CfgDataW-1:0] cfg_data,
    tsha_stream_if.sink                  in_ch,
    tsha_stream_if.source                out_ch
);
    typedef enum logic [3:0] {
        S_IDLE, S_RDIV, S_RWAIT, S_MDIV, S_MWAIT, S_MFIX, S_NORM, S_SQ,
        S_LN, S_POLY, S_PADD, S_QDIV, S_QWAIT, S_OUT
    } state_t;

    state_t state_reg;
    logic        sensor_type_reg;
    logic [23:0] reference_ohms_reg;
    logic [3:0]  supply_volts_reg;
    logic [5:0]  batch_count_reg;
    logic [39:0] acc_reg;
    logic        zero_flag_reg;
    logic [9:0]  sample_reg;
    logic [33:0] mean_reg;
    logic [39:0] mq_reg;
    logic [39:0] mr_reg;
    logic [5:0]  exp_reg;
    logic [32:0] m_reg;
    logic [25:0] frac_reg;
    logic [4:0]  step_reg;
    logic [29:0] l24_reg;
    logic signed [40:0] p_reg;
    logic [1:0]  cidx_reg;
    logic        neg_reg;
    logic signed [80:0] prod_reg;
    tsha_pkg::out_item_t out_reg;
    logic        out_valid_reg;

    logic        div_start;
    logic [63:0] div_dividend;
    logic [39:0] div_divisor;
    logic        div_done;
    logic [63:0] div_q;
    logic [40:0] p_abs;

    tsha_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
        .divisor(div_divisor), .done(div_done), .quotient(div_q)
    );

    assign p_abs = p_reg[40] ? 41'(-p_reg) : 41'(p_reg);

    // Divider operand selection by phase
    always_comb
    begin
        div_start = 1'b0;
        div_dividend = '0;
        div_divisor = '0;
        unique case (state_reg)
            S_RDIV:
            begin
                div_start = 1'b1;
                div_dividend = 64'(reference_ohms_reg) *
                    64'(11'(tsha_pkg::AdcFullScale) - {1'b0, sample_reg});
                div_divisor = 40'(sample_reg);
            end
            S_QDIV:
            begin
                div_start = 1'b1;
                div_dividend = (64'd1 << 32) + 64'(p_abs >> 1);
                div_divisor = p_abs[39:0];
            end
            default: ;
        endcase
    end

    logic [63:0] sq;
    logic signed [80:0] pmul;
    logic signed [80:0] pfl;
    logic [63:0] lnp;
    logic [33:0] rsel;
    logic [33:0] mclip;
    logic [9:0]  s_clamped;
    assign sq = m_reg[31:0] * m_reg[31:0];
    assign pmul = $signed(p_reg[31:0]) * $signed({1'b0, l24_reg});
    assign pfl = prod_reg >>> 24;
    assign lnp = 64'({exp_reg, frac_reg}) * 64'(tsha_pkg::LN2_Q32) + (64'd1 << 31);
    assign rsel = (div_q > 64'(tsha_pkg::RES_MAX)) ? tsha_pkg::RES_MAX : div_q[33:0];
    assign mclip = (mq_reg > 40'(tsha_pkg::RES_MAX)) ? tsha_pkg::RES_MAX : mq_reg[33:0];
    assign s_clamped = (in_ch.data.adc_sample == 10'd0) ? 10'd1 : in_ch.data.adc_sample;
    assign in_ch.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = out_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_type_reg <= 1'b0;
            reference_ohms_reg <= 24'd10000;
            supply_volts_reg <= 4'd5;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tsha_pkg::CFG_SENSOR_TYPE: sensor_type_reg <= cfg_data[0];
                tsha_pkg::CFG_REFERENCE_OHMS: reference_ohms_reg <= cfg_data;
                tsha_pkg::CFG_SUPPLY_VOLTS: supply_volts_reg <= cfg_data[3:0];
                default: supply_volts_reg <= supply_volts_reg;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            batch_count_reg <= '0;
            acc_reg <= '0;
            zero_flag_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (in_ch.valid && in_ch.ready)
                    begin
                        sample_reg <= s_clamped;
                        if (in_ch.data.adc_sample == 10'd0)
                            zero_flag_reg <= 1'b1;
                        state_reg <= S_RDIV;
                    end
                S_RDIV: state_reg <= S_RWAIT;
                S_RWAIT:
                    if (div_done)
                    begin
                        acc_reg <= acc_reg + 40'(rsel);
                        batch_count_reg <= batch_count_reg + 6'd1;
                        state_reg <= (batch_count_reg + 6'd1 >= 6'(tsha_pkg::BatchSamples))
                            ? S_MDIV : S_IDLE;
                    end
                // Divide by ten: x*0.8 by shift-adds, then /8, then fix-up
                S_MDIV:
                begin
                    mq_reg <= (acc_reg >> 1) + (acc_reg >> 2);
                    step_reg <= '0;
                    state_reg <= S_MWAIT;
                end
                S_MWAIT:
                begin
                    case (step_reg)
                        5'd0: mq_reg <= mq_reg + (mq_reg >> 4);
                        5'd1: mq_reg <= mq_reg + (mq_reg >> 8);
                        5'd2: mq_reg <= mq_reg + (mq_reg >> 16);
                        5'd3: mq_reg <= mq_reg + (mq_reg >> 32);
                        5'd4: mq_reg <= mq_reg >> 3;
                        default:
                        begin
                            mr_reg <= acc_reg - {mq_reg[36:0], 3'b000}
                                - {mq_reg[38:0], 1'b0};
                            state_reg <= S_MFIX;
                        end
                    endcase
                    step_reg <= step_reg + 5'd1;
                end
                // Quotient estimate is never high; step it up while remainder >= 10
                S_MFIX:
                    if (mr_reg >= 40'(tsha_pkg::BatchSamples))
                    begin
                        mq_reg <= mq_reg + 40'd1;
                        mr_reg <= mr_reg - 40'(tsha_pkg::BatchSamples);
                    end
                    else
                    begin
                        mean_reg <= mclip;
                        state_reg <= S_NORM;
                    end
                S_NORM:
                begin
                    // Find exponent and normalize to Q1.31
                    logic [33:0] r;
                    logic [5:0]  e;
                    r = (mean_reg == '0) ? 34'd1 : mean_reg;
                    e = '0;
                    for (int i = 0; i < 34; i++)
                        if (r[i]) e = 6'(i);
                    exp_reg <= e;
                    m_reg <= (e <= 6'd31) ? 33'(r << (6'd31 - e)) : 33'(r >> (e - 6'd31));
                    frac_reg <= '0;
                    step_reg <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    if (sq[63])
                    begin
                        m_reg <= 33'(sq >> 32);
                        frac_reg <= {frac_reg[24:0], 1'b1};
                    end
                    else
                    begin
                        m_reg <= 33'(sq >> 31);
                        frac_reg <= {frac_reg[24:0], 1'b0};
                    end
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'd25)
                        state_reg <= S_LN;
                end
                S_LN:
                begin
                    l24_reg <= lnp[63:34];
                    p_reg <= 41'(tsha_pkg::coef(sensor_type_reg, 2'd3));
                    cidx_reg <= 2'd2;
                    state_reg <= S_POLY;
                end
                S_POLY:
                begin
                    prod_reg <= pmul;
                    state_reg <= S_PADD;
                end
                S_PADD:
                begin
                    p_reg <= 41'(pfl) + 41'(tsha_pkg::coef(sensor_type_reg, cidx_reg));
                    if (cidx_reg == 2'd0)
                        state_reg <= S_QDIV;
                    else
                    begin
                        cidx_reg <= cidx_reg - 2'd1;
                        state_reg <= S_POLY;
                    end
                end
                S_QDIV:
                begin
                    neg_reg <= p_reg[40];
                    if (p_reg == '0)
                    begin
                        out_reg.temperature_q8_8 <= 16'sd32767;
                        out_reg.result_saturated <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_QWAIT;
                end
                S_QWAIT:
                    if (div_done)
                    begin
                        if (!neg_reg)
                        begin
                            out_reg.result_saturated <= div_q > 64'd32767;
                            out_reg.temperature_q8_8 <= (div_q > 64'd32767) ? 16'sd32767
                                : $signed(div_q[15:0]);
                        end
                        else
                        begin
                            out_reg.result_saturated <= div_q > 64'd32768;
                            out_reg.temperature_q8_8 <= (div_q > 64'd32768) ? -16'sd32768
                                : $signed(16'(-div_q[15:0]));
                        end
                        state_reg <= S_OUT;
                    end
                S_OUT:
                    if (!out_valid_reg)
                    begin
                        out_reg.mean_resistance_ohms <= mean_reg;
                        out_reg.zero_sample_seen <= zero_flag_reg;
                        out_valid_reg <= 1'b1;
                        batch_count_reg <= '0;
                        acc_reg <= '0;
                        zero_flag_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- design/tsha_checker.sv -----
// Port-level checks for the thermistor averager, bound to the top level
module tsha_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input tsha_pkg::out_item_t out_data
);
    // A held result keeps its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data)) else $error("result changed");
    // Input is not taken while a result waits
    a_noin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    // An accepted sample drops ready next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("ready after accept");
    // Saturation only on the end codes
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_saturated |->
        (out_data.temperature_q8_8 == 16'sd32767 || out_data.temperature_q8_8 == -16'sd32768))
        else $error("saturated flag without clipped value");
endmodule

bind thermistor_steinhart_hart_averager_top tsha_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
